// ===== sv/constrained_best_fit_selector_defines.svh =====
// assertion macros used by the checker file
`ifndef CONSTRAINED_BEST_FIT_SELECTOR_DEFINES_SVH
`define CONSTRAINED_BEST_FIT_SELECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CBFS_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication, checked outside reset
`define CBFS_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== sv/cbfs_pkg.sv =====
// ---------------------------------------------------------------------------
// cbfs_pkg
// shared types, command codes and helpers of the best-fit selector
// ---------------------------------------------------------------------------
package cbfs_pkg;

    localparam int SIDE_W  = 9;
    localparam int INDEX_W = 8;
    localparam int KEY_W   = SIDE_W + 1;
    localparam int TIE_W   = 2 * SIDE_W;

    // command codes
    localparam logic [2:0] MODE_WRITE     = 3'd0;
    localparam logic [2:0] MODE_FIRST     = 3'd1;
    localparam logic [2:0] MODE_MANHATTAN = 3'd2;
    localparam logic [2:0] MODE_SET       = 3'd3;
    localparam logic [2:0] MODE_CLEAR     = 3'd4;

    typedef struct packed {
        logic [2:0]         mode;
        logic [INDEX_W-1:0] entry_index;
        logic [SIDE_W-1:0]  rect_width;
        logic [SIDE_W-1:0]  rect_height;
        logic               is_square;
        logic               placed_value;
        logic [SIDE_W-1:0]  limit_width;
        logic [SIDE_W-1:0]  limit_height;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] chosen_index;
        logic [SIDE_W-1:0]  chosen_width;
        logic [SIDE_W-1:0]  chosen_height;
    } rsp_t;

    // contents of one table cell
    typedef struct packed {
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic              square;
        logic              placed;
        logic              valid;
    } entry_t;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic   shift;
        logic   write;
        logic   set_placed;
        logic   placed_value;
        logic   clear_placed;
        entry_t wdata;
    } cell_ctl_t;

    // clamp a side to the largest allowed value
    function automatic logic [SIDE_W-1:0] sat_side(logic [SIDE_W-1:0] x, int unsigned max_side);
        logic [31:0] xe;
        logic [31:0] me;
        xe = 32'(x);
        me = 32'(max_side);
        return (xe > me) ? me[SIDE_W-1:0] : x;
    endfunction

endpackage

// ===== sv/cbfs_cmd_if.sv =====
// ---------------------------------------------------------------------------
// cbfs_cmd_if
// command channel of the selector
// ---------------------------------------------------------------------------
interface cbfs_cmd_if;
    logic          valid;
    logic          ready;
    cbfs_pkg::cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/cbfs_rsp_if.sv =====
// ---------------------------------------------------------------------------
// cbfs_rsp_if
// response channel of the selector
// ---------------------------------------------------------------------------
interface cbfs_rsp_if;
    logic          valid;
    logic          ready;
    cbfs_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/cbfs_cell.sv =====
// ---------------------------------------------------------------------------
// cbfs_cell
// one table entry; shifts to its neighbor while the ring rotates
// ---------------------------------------------------------------------------
module cbfs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  cbfs_pkg::cell_ctl_t ctl,
    input  logic                sel,
    input  cbfs_pkg::entry_t    nbr,
    output cbfs_pkg::entry_t    entry
);

    cbfs_pkg::entry_t entry_reg;
    cbfs_pkg::entry_t entry_next;

    // rotate, or apply a write or placed-mark update
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            entry_next = nbr;
        end
        else
        begin
            if (ctl.write && sel)
            begin
                entry_next = ctl.wdata;
            end
            if (ctl.set_placed && sel)
            begin
                entry_next.placed = ctl.placed_value;
            end
            if (ctl.clear_placed)
            begin
                entry_next.placed = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== sv/cbfs_eval.sv =====
// ---------------------------------------------------------------------------
// cbfs_eval
// scores the entry at the head of the ring and keeps the best so far
// ---------------------------------------------------------------------------
module cbfs_eval #(
    parameter int IDX_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          step,
    input  logic [IDX_W-1:0]              step_idx,
    input  cbfs_pkg::entry_t              head,
    input  logic                          first_mode,
    input  logic [cbfs_pkg::SIDE_W-1:0]   lim_max,
    input  logic [cbfs_pkg::SIDE_W-1:0]   lim_min,
    output logic                          have,
    output logic [IDX_W-1:0]              best_idx,
    output logic [cbfs_pkg::SIDE_W-1:0]   best_w,
    output logic [cbfs_pkg::SIDE_W-1:0]   best_h
);

    localparam int SW = cbfs_pkg::SIDE_W;
    localparam int KW = cbfs_pkg::KEY_W;
    localparam int TW = cbfs_pkg::TIE_W;

    logic [SW-1:0]    e_max;
    logic [SW-1:0]    e_min;
    logic             e_elig;
    logic [KW-1:0]    e_key;
    logic [TW-1:0]    e_tie;

    logic             s1_v_reg;
    logic             s1_elig_reg;
    logic [KW-1:0]    s1_key_reg;
    logic [TW-1:0]    s1_tie_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [SW-1:0]    s1_w_reg;
    logic [SW-1:0]    s1_h_reg;

    logic             have_reg;
    logic [KW-1:0]    best_key_reg;
    logic [TW-1:0]    best_tie_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [SW-1:0]    best_w_reg;
    logic [SW-1:0]    best_h_reg;
    logic             better;

    // fit test and score of the head entry
    always_comb
    begin
        e_max  = (head.w > head.h) ? head.w : head.h;
        e_min  = (head.w > head.h) ? head.h : head.w;
        e_elig = head.valid && !head.placed && (e_max <= lim_max) && (e_min <= lim_min);
        if (first_mode)
        begin
            e_key = KW'(e_max);
            e_tie = TW'(head.w) * TW'(head.h);
        end
        else
        begin
            e_key = KW'(head.w) + KW'(head.h);
            e_tie = TW'(head.square);
        end
    end

    // score stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_elig_reg <= e_elig;
        s1_key_reg  <= e_key;
        s1_tie_reg  <= e_tie;
        s1_idx_reg  <= step_idx;
        s1_w_reg    <= head.w;
        s1_h_reg    <= head.h;
    end

    // lower index wins a full tie since entries arrive in order
    assign better = !have_reg || (s1_key_reg > best_key_reg)
                    || ((s1_key_reg == best_key_reg) && (s1_tie_reg > best_tie_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (start)
        begin
            have_reg <= 1'b0;
        end
        else if (s1_v_reg && s1_elig_reg && better)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!start && s1_v_reg && s1_elig_reg && better)
        begin
            best_key_reg <= s1_key_reg;
            best_tie_reg <= s1_tie_reg;
            best_idx_reg <= s1_idx_reg;
            best_w_reg   <= s1_w_reg;
            best_h_reg   <= s1_h_reg;
        end
    end

    assign have     = have_reg;
    assign best_idx = best_idx_reg;
    assign best_w   = best_w_reg;
    assign best_h   = best_h_reg;

endmodule

// ===== sv/constrained_best_fit_selector.sv =====
// ---------------------------------------------------------------------------
// constrained_best_fit_selector
// table of rectangles with best-fit selection under a limit rectangle
// ---------------------------------------------------------------------------
// cmd carries one command per beat: write an entry, set or clear placed
// marks, or query with a limit rectangle (first or manhattan ranking).
// rsp returns exactly one beat per command; only queries can report found.
// entries sit in a ring of cells; a query rotates the ring once, scoring
// the head cell each cycle, then passes through the drain and result
// states before its beat is loaded into the response register.
// writes and placed updates go from accept straight to the result state.
// one command is in work at a time; cmd.ready is high while idle, and a
// new command is taken while the previous response still waits on rsp.
// reset empties the table at once (every cell cleared), no sweep needed.
// when rsp stalls, the response register holds its beat and the next
// finished command waits until that beat is taken.
// ---------------------------------------------------------------------------
module constrained_best_fit_selector #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_SIDE      = 256
) (
    input logic       clk,
    input logic       rst_n,
    cbfs_cmd_if.sink  cmd,
    cbfs_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int SW    = cbfs_pkg::SIDE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [IDX_W-1:0]     cnt_reg;
    logic                 query_reg;
    logic                 first_reg;
    logic [SW-1:0]        lim_max_reg;
    logic [SW-1:0]        lim_min_reg;
    logic                 rsp_valid_reg;
    cbfs_pkg::rsp_t       rsp_reg;

    logic                 accept;
    logic                 is_query;
    logic                 in_range;
    logic [SW-1:0]        lw;
    logic [SW-1:0]        lh;
    logic                 load_rsp;
    cbfs_pkg::cell_ctl_t  ctl;
    cbfs_pkg::entry_t     cells [TABLE_ENTRIES];

    logic                 have;
    logic [IDX_W-1:0]     best_idx;
    logic [SW-1:0]        best_w;
    logic [SW-1:0]        best_h;
    logic [31:0]          best_idx_ext;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign is_query  = (cmd.payload.mode == cbfs_pkg::MODE_FIRST)
                       || (cmd.payload.mode == cbfs_pkg::MODE_MANHATTAN);
    assign in_range  = (32'(cmd.payload.entry_index) < 32'(TABLE_ENTRIES));
    assign lw = cbfs_pkg::sat_side(cmd.payload.limit_width, MAX_SIDE);
    assign lh = cbfs_pkg::sat_side(cmd.payload.limit_height, MAX_SIDE);

    // broadcast controls to the cells
    always_comb
    begin
        ctl.shift        = (state_reg == ST_SCAN);
        ctl.write        = accept && in_range && (cmd.payload.mode == cbfs_pkg::MODE_WRITE);
        ctl.set_placed   = accept && in_range && (cmd.payload.mode == cbfs_pkg::MODE_SET);
        ctl.placed_value = cmd.payload.placed_value;
        ctl.clear_placed = accept && (cmd.payload.mode == cbfs_pkg::MODE_CLEAR);
        ctl.wdata.w      = cbfs_pkg::sat_side(cmd.payload.rect_width, MAX_SIDE);
        ctl.wdata.h      = cbfs_pkg::sat_side(cmd.payload.rect_height, MAX_SIDE);
        ctl.wdata.square = cmd.payload.is_square;
        ctl.wdata.placed = 1'b0;
        ctl.wdata.valid  = 1'b1;
    end

    // ring of cells, each handing its entry to the lower neighbor
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        cbfs_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .sel   (32'(cmd.payload.entry_index) == 32'(i)),
            .nbr   (cells[(i + 1) % TABLE_ENTRIES]),
            .entry (cells[i])
        );
    end

    cbfs_eval #(
        .IDX_W (IDX_W)
    ) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept && is_query),
        .step       (state_reg == ST_SCAN),
        .step_idx   (cnt_reg),
        .head       (cells[0]),
        .first_mode (first_reg),
        .lim_max    (lim_max_reg),
        .lim_min    (lim_min_reg),
        .have       (have),
        .best_idx   (best_idx),
        .best_w     (best_w),
        .best_h     (best_h)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_query ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (load_rsp)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign load_rsp = (state_reg == ST_RESULT) && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // query context latched on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg   <= is_query;
            first_reg   <= (cmd.payload.mode == cbfs_pkg::MODE_FIRST);
            lim_max_reg <= (lw > lh) ? lw : lh;
            lim_min_reg <= (lw > lh) ? lh : lw;
        end
    end

    // response register
    assign best_idx_ext = 32'(best_idx);

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            if (query_reg && have)
            begin
                rsp_reg.found         <= 1'b1;
                rsp_reg.chosen_index  <= best_idx_ext[cbfs_pkg::INDEX_W-1:0];
                rsp_reg.chosen_width  <= best_w;
                rsp_reg.chosen_height <= best_h;
            end
            else
            begin
                rsp_reg <= '0;
            end
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

endmodule

// ===== sv/cbfs_checker.sv =====
// ---------------------------------------------------------------------------
// cbfs_checker
// port-level checks of the selector, bound to the top level
// ---------------------------------------------------------------------------
`include "constrained_best_fit_selector_defines.svh"

module cbfs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input cbfs_pkg::rsp_t rsp_payload
);

    logic cmd_fire;
    logic rsp_stall;
    logic miss_beat;
    logic fields_zero;

    // handshake and field summaries
    assign cmd_fire    = cmd_valid && cmd_ready;
    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign miss_beat   = rsp_valid && !rsp_payload.found;
    assign fields_zero = (rsp_payload.chosen_index == '0)
                         && (rsp_payload.chosen_width == '0)
                         && (rsp_payload.chosen_height == '0);

    // a miss or a non-query beat carries all-zero fields
    `CBFS_ASSERT_NOW(a_miss_zero, miss_beat, fields_zero, "nonzero fields without found")

    // one command in work at a time
    `CBFS_ASSERT_NEXT(a_busy_after_accept, cmd_fire, !cmd_ready, "command taken while busy")

    // a stalled response beat holds
    `CBFS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled beat changed")

endmodule

bind constrained_best_fit_selector cbfs_checker u_cbfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
